// ===== rtl/irpfd_pkg.sv =====
// Package for the infrared pulse frame decoder.
// Holds payload structs, register indexes, status codes and reset values.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package irpfd_pkg;

  localparam int DATA_BITS_DEFAULT = 32;

  localparam int DUR_W    = 16;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 3'd0,
    ST_BAD_LEADER_MARK  = 3'd1,
    ST_BAD_LEADER_SPACE = 3'd2,
    ST_BAD_DATA_MARK    = 3'd3,
    ST_BAD_STOP_MARK    = 3'd4
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LEADER_MARK_MIN  = 3'd0,
    REG_LEADER_MARK_MAX  = 3'd1,
    REG_LEADER_SPACE_MIN = 3'd2,
    REG_LEADER_SPACE_MAX = 3'd3,
    REG_BIT_MARK_MIN     = 3'd4,
    REG_BIT_MARK_MAX     = 3'd5,
    REG_ONE_SPACE_THRESH = 3'd6
  } reg_index_t;

  localparam logic [DUR_W-1:0] RST_LEADER_MARK_MIN  = 16'd8500;
  localparam logic [DUR_W-1:0] RST_LEADER_MARK_MAX  = 16'd10000;
  localparam logic [DUR_W-1:0] RST_LEADER_SPACE_MIN = 16'd4000;
  localparam logic [DUR_W-1:0] RST_LEADER_SPACE_MAX = 16'd5500;
  localparam logic [DUR_W-1:0] RST_BIT_MARK_MIN     = 16'd300;
  localparam logic [DUR_W-1:0] RST_BIT_MARK_MAX     = 16'd700;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE_THRESH = 16'd1000;

  typedef struct packed {
    logic             start_of_frame;
    logic [DUR_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   data_word;
  } out_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] leader_mark_min;
    logic [DUR_W-1:0] leader_mark_max;
    logic [DUR_W-1:0] leader_space_min;
    logic [DUR_W-1:0] leader_space_max;
    logic [DUR_W-1:0] bit_mark_min;
    logic [DUR_W-1:0] bit_mark_max;
    logic [DUR_W-1:0] one_space_threshold;
  } cfg_regs_t;

  // Control outcome of one decode step.
  typedef struct packed {
    logic emit;
    logic open_next;
  } step_ctl_t;

endpackage

// ===== rtl/irpfd_step.sv =====
// One decode step of the infrared pulse frame decoder (combinational).
// Depends on irpfd_pkg for payload, configuration and status types.
`timescale 1ns / 1ps

module irpfd_step #(
  parameter int DATA_BITS = irpfd_pkg::DATA_BITS_DEFAULT,
  parameter int POS_W     = $clog2(2 * DATA_BITS + 3)
) (
  input  irpfd_pkg::cfg_regs_t         cfg,
  input  irpfd_pkg::in_item_t          item,
  input  logic                         frame_open,
  input  logic [POS_W-1:0]             frame_position,
  input  logic [irpfd_pkg::WORD_W-1:0] shift_reg,
  output irpfd_pkg::step_ctl_t         ctl,
  output logic [POS_W-1:0]             position_next,
  output logic [irpfd_pkg::WORD_W-1:0] shift_reg_next,
  output irpfd_pkg::out_item_t         result
);
  import irpfd_pkg::*;

  localparam logic [POS_W-1:0] STOP_POS = POS_W'(2 * DATA_BITS + 2);
  localparam logic [POS_W-1:0] POS_LEADER_SPACE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST_BIT = POS_W'(2);

  logic in_leader_mark;
  logic in_leader_space;
  logic in_bit_mark;
  logic is_one;

  assign in_leader_mark  = (item.duration >= cfg.leader_mark_min) &&
                           (item.duration <= cfg.leader_mark_max);
  assign in_leader_space = (item.duration >= cfg.leader_space_min) &&
                           (item.duration <= cfg.leader_space_max);
  assign in_bit_mark     = (item.duration >= cfg.bit_mark_min) &&
                           (item.duration <= cfg.bit_mark_max);
  assign is_one          = item.duration > cfg.one_space_threshold;

  always_comb begin
    ctl.emit       = 1'b0;
    ctl.open_next  = frame_open;
    position_next  = frame_position;
    shift_reg_next = shift_reg;
    result.status  = ST_OK;

    if (item.start_of_frame) begin
      shift_reg_next = '0;
      if (!in_leader_mark) begin
        ctl.emit      = 1'b1;
        ctl.open_next = 1'b0;
        position_next = '0;
        result.status = ST_BAD_LEADER_MARK;
      end else begin
        ctl.open_next = 1'b1;
        position_next = POS_LEADER_SPACE;
      end
    end else if (frame_open) begin
      if (frame_position == POS_LEADER_SPACE) begin
        if (!in_leader_space) begin
          ctl.emit      = 1'b1;
          result.status = ST_BAD_LEADER_SPACE;
        end else begin
          position_next = POS_FIRST_BIT;
        end
      end else if (frame_position >= STOP_POS) begin
        ctl.emit      = 1'b1;
        result.status = in_bit_mark ? ST_OK : ST_BAD_STOP_MARK;
      end else if (!frame_position[0]) begin
        if (!in_bit_mark) begin
          ctl.emit      = 1'b1;
          result.status = ST_BAD_DATA_MARK;
        end else begin
          position_next = frame_position + POS_W'(1);
        end
      end else begin
        shift_reg_next = {shift_reg[WORD_W-2:0], is_one};
        position_next  = frame_position + POS_W'(1);
      end
      // Any emitted result closes the frame.
      if (ctl.emit) begin
        ctl.open_next = 1'b0;
        position_next = '0;
      end
    end
    result.data_word = shift_reg_next;
  end

endmodule

// ===== rtl/ir_pulse_frame_decoder.sv =====
// Top level of the infrared pulse frame decoder.
// Depends on irpfd_pkg and instantiates irpfd_step.
// Holds the configuration registers, the item register, the frame state and the result register.
`timescale 1ns / 1ps

// The decoder takes one measured mark or space duration per transfer and
// walks an NEC-style frame: leader mark, leader space, DATA_BITS mark/space
// pairs and a stop mark. Each transfer with start_of_frame set opens a new
// frame, dropping any frame in progress. One result transfer (status and the
// bits collected so far, first bit most significant, last 32 kept) leaves at
// the stop mark or at the first failed window check; durations that arrive
// while no frame is open are discarded. Throughput is one input transfer per
// clock while the input is not stalled: an accepted item sits in a single item
// register, the decode step is one set of window compares and a shift, and its
// outcome is written to the frame state and the result register when the item
// retires. A held result stalls the input only when the next item would itself
// produce a result. Configuration registers are always ready and must be
// written only while the decoder is idle.
module ir_pulse_frame_decoder #(
  parameter int DATA_BITS = irpfd_pkg::DATA_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  irpfd_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output irpfd_pkg::out_item_t          out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [irpfd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [irpfd_pkg::DUR_W-1:0]   cfg_data
);
  import irpfd_pkg::*;

  localparam int POS_W = $clog2(2 * DATA_BITS + 3);

  // Configuration registers.
  cfg_regs_t cfg;

  // Item register between the input channel and the decode step.
  logic     item_valid;
  in_item_t item;

  // Frame state.
  logic              frame_open;
  logic [POS_W-1:0]  frame_position;
  logic [WORD_W-1:0] shift_reg;

  // Decode step outputs.
  step_ctl_t         ctl;
  logic [POS_W-1:0]  position_next;
  logic [WORD_W-1:0] shift_reg_next;
  out_item_t         result;

  logic step_go;
  logic in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_mark_min     <= RST_LEADER_MARK_MIN;
      cfg.leader_mark_max     <= RST_LEADER_MARK_MAX;
      cfg.leader_space_min    <= RST_LEADER_SPACE_MIN;
      cfg.leader_space_max    <= RST_LEADER_SPACE_MAX;
      cfg.bit_mark_min        <= RST_BIT_MARK_MIN;
      cfg.bit_mark_max        <= RST_BIT_MARK_MAX;
      cfg.one_space_threshold <= RST_ONE_SPACE_THRESH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEADER_MARK_MIN:  cfg.leader_mark_min     <= cfg_data;
        REG_LEADER_MARK_MAX:  cfg.leader_mark_max     <= cfg_data;
        REG_LEADER_SPACE_MIN: cfg.leader_space_min    <= cfg_data;
        REG_LEADER_SPACE_MAX: cfg.leader_space_max    <= cfg_data;
        REG_BIT_MARK_MIN:     cfg.bit_mark_min        <= cfg_data;
        REG_BIT_MARK_MAX:     cfg.bit_mark_max        <= cfg_data;
        REG_ONE_SPACE_THRESH: cfg.one_space_threshold <= cfg_data;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  irpfd_step #(
    .DATA_BITS (DATA_BITS),
    .POS_W     (POS_W)
  ) u_step (
    .cfg            (cfg),
    .item           (item),
    .frame_open     (frame_open),
    .frame_position (frame_position),
    .shift_reg      (shift_reg),
    .ctl            (ctl),
    .position_next  (position_next),
    .shift_reg_next (shift_reg_next),
    .result         (result)
  );

  // The held item retires unless it needs the result register while that
  // register still holds a result the consumer has not taken.
  assign step_go  = item_valid && (!ctl.emit || !out_valid || !out_stall);
  assign in_stall = item_valid && !step_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (step_go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      frame_position <= '0;
      shift_reg      <= '0;
    end else if (step_go) begin
      frame_open     <= ctl.open_next;
      frame_position <= position_next;
      shift_reg      <= shift_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && ctl.emit) begin
      out_data <= result;
    end
  end

endmodule

// ===== sim/tb_ir_pulse_frame_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ir_pulse_frame_decoder: drives pulse durations and
// register writes, predicts every frame report locally and checks the decoder output.
// Depends on irpfd_pkg and the decoder RTL only.

module tb_ir_pulse_frame_decoder;
  import irpfd_pkg::*;

  localparam int DATA_BITS      = DATA_BITS_DEFAULT;
  // Frame entry index of the stop mark: leader mark, leader space, then
  // one mark/space pair per data bit.
  localparam int STOP_POS       = 2 * DATA_BITS + 2;
  localparam int REG_COUNT      = int'(REG_ONE_SPACE_THRESH) + 1;
  // The index field has room for one more register than the decoder has.
  // Writes there must leave every timing window untouched.
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int MAX_DUR        = 65535;
  localparam int IDLE_PCT       = 9;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 200;
  localparam int CYCLE_LIMIT    = 400000;

  typedef logic [DUR_W-1:0] timing_set_t [REG_COUNT];

  // Power-up timing windows, in register index order.
  localparam timing_set_t DEFAULT_TIMING = '{
    RST_LEADER_MARK_MIN, RST_LEADER_MARK_MAX, RST_LEADER_SPACE_MIN,
    RST_LEADER_SPACE_MAX, RST_BIT_MARK_MIN, RST_BIT_MARK_MAX, RST_ONE_SPACE_THRESH
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [DUR_W-1:0]     cfg_data;

  ir_pulse_frame_decoder #(
    .DATA_BITS(DATA_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the decoder state. It is advanced at every accepted
  // transfer, so the windows used for prediction are always the ones
  // the decoder itself holds.
  timing_set_t          timing;
  bit                   frame_open;
  int                   frame_pos;
  logic [WORD_W-1:0]    shifted_bits;

  // Frame reports predicted but not yet seen at the output, oldest first.
  out_item_t            frame_reports_due [$];

  int                   engaged_items;
  int                   errors;
  int                   cycles;
  // While quiet is set neither side inserts random idle cycles.
  bit                   quiet;
  // A test asks for a long receiver hold-off here; the receiver process
  // takes the request and counts it down on its own.
  int                   hold_request;
  int                   hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit in_window(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
                                   logic [DUR_W-1:0] hi);
    return d >= lo && d <= hi;
  endfunction

  // Ends the open frame and builds its report from the bits collected so far.
  function automatic out_item_t close_frame(status_t st);
    out_item_t rep;
    rep.status    = st;
    rep.data_word = shifted_bits;
    frame_open    = 1'b0;
    frame_pos     = 0;
    return rep;
  endfunction

  // Advances the local frame state by one accepted duration. Returns 1 when
  // the duration ends the frame, with the report the decoder must produce.
  function automatic bit decode_pulse(input in_item_t item, output out_item_t rep);
    logic [DUR_W-1:0] d;
    d   = item.duration;
    rep = '0;
    // A start flag always opens a new frame, dropping any frame in progress
    // without a report.
    if (item.start_of_frame) begin
      shifted_bits = '0;
      frame_open   = 1'b1;
      frame_pos    = 1;
      if (in_window(d, timing[REG_LEADER_MARK_MIN], timing[REG_LEADER_MARK_MAX]))
        return 1'b0;
      rep = close_frame(ST_BAD_LEADER_MARK);
      return 1'b1;
    end
    // Durations outside a frame, trailing spaces among them, are dropped.
    if (!frame_open)
      return 1'b0;
    if (frame_pos == 1) begin
      if (in_window(d, timing[REG_LEADER_SPACE_MIN], timing[REG_LEADER_SPACE_MAX])) begin
        frame_pos = 2;
        return 1'b0;
      end
      rep = close_frame(ST_BAD_LEADER_SPACE);
      return 1'b1;
    end
    // The stop mark shares the data mark window.
    if (frame_pos >= STOP_POS) begin
      rep = close_frame(in_window(d, timing[REG_BIT_MARK_MIN], timing[REG_BIT_MARK_MAX]) ?
                        ST_OK : ST_BAD_STOP_MARK);
      return 1'b1;
    end
    if (frame_pos % 2 == 0) begin
      if (!in_window(d, timing[REG_BIT_MARK_MIN], timing[REG_BIT_MARK_MAX])) begin
        rep = close_frame(ST_BAD_DATA_MARK);
        return 1'b1;
      end
    end else begin
      // A space strictly longer than the threshold is a one; bits enter at
      // the bottom so the first one received ends up on top.
      shifted_bits = {shifted_bits[WORD_W-2:0], d > timing[REG_ONE_SPACE_THRESH]};
    end
    frame_pos++;
    return 1'b0;
  endfunction

  // Draws a mark duration inside [lo, hi], or outside it when bad is set.
  // A quarter of the bad picks land right next to the window edge.
  function automatic logic [DUR_W-1:0] pick_mark(bit bad, int lo, int hi);
    bit below_ok;
    bit above_ok;
    below_ok = lo > 0;
    above_ok = hi < MAX_DUR;
    if (!bad)
      return (lo > hi) ? DUR_W'($urandom) : DUR_W'($urandom_range(hi, lo));
    if (lo > hi || (!below_ok && !above_ok))
      return DUR_W'($urandom);
    if (below_ok && (!above_ok || $urandom_range(1, 0) == 0))
      return ($urandom_range(3, 0) == 0) ? DUR_W'(lo - 1) : DUR_W'($urandom_range(lo - 1, 0));
    return ($urandom_range(3, 0) == 0) ? DUR_W'(hi + 1) : DUR_W'($urandom_range(MAX_DUR, hi + 1));
  endfunction

  // Draws a data space that decodes to the given bit under the current
  // threshold, hitting the threshold itself now and then. With the threshold
  // at full scale no space can decode as a one.
  function automatic logic [DUR_W-1:0] pick_space(bit one);
    int thr;
    thr = timing[REG_ONE_SPACE_THRESH];
    if (one && thr >= MAX_DUR)
      return DUR_W'(MAX_DUR);
    if ($urandom_range(7, 0) == 0)
      return one ? DUR_W'(thr + 1) : DUR_W'(thr);
    return one ? DUR_W'($urandom_range(MAX_DUR, thr + 1)) : DUR_W'($urandom_range(thr, 0));
  endfunction

  // Offers one duration and returns once the decoder has taken it. Valid is
  // only lowered for a random idle gap, so back-to-back items keep it high.
  task automatic send_pulse(input bit sof, input logic [DUR_W-1:0] dur);
    if (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!quiet && $urandom_range(99, 0) < IDLE_PCT)
        @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {sof, dur};
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Sends a frame carrying word, first bit on top. nbits data bits follow the
  // leader; the entry at break_at (if any) is corrupted; without with_stop the
  // frame is cut short before its stop mark. After a stop mark a trailing space
  // is sent half of the time, which the decoder has to drop.
  task automatic send_frame(input logic [WORD_W-1:0] word, input int nbits,
                            input int break_at, input bit with_stop);
    int last;
    int bit_i;
    bit one;
    logic [DUR_W-1:0] dur;
    last = with_stop ? 2 + 2 * nbits : 1 + 2 * nbits;
    for (int k = 0; k <= last; k++) begin
      if (k == 0) begin
        dur = pick_mark(k == break_at, timing[REG_LEADER_MARK_MIN], timing[REG_LEADER_MARK_MAX]);
      end else if (k == 1) begin
        dur = pick_mark(k == break_at, timing[REG_LEADER_SPACE_MIN],
                        timing[REG_LEADER_SPACE_MAX]);
      end else if (k % 2 == 1) begin
        bit_i = (k - 3) / 2;
        one   = (bit_i < WORD_W) ? word[WORD_W - 1 - bit_i] : 1'($urandom_range(1, 0));
        dur   = (k == break_at) ? DUR_W'($urandom) : pick_space(one);
      end else begin
        dur = pick_mark(k == break_at, timing[REG_BIT_MARK_MIN], timing[REG_BIT_MARK_MAX]);
      end
      send_pulse(k == 0, dur);
    end
    if (with_stop && $urandom_range(1, 0) == 1)
      send_pulse(1'b0, pick_space(1'($urandom_range(1, 0))));
  endtask

  // Drops valid and waits for every predicted report, then a few cycles more
  // so that an item which ends in no report has left the pipeline as well.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all timing registers in index order, optionally followed by a
  // write to the unmapped index. Only called while the decoder is idle.
  task automatic program_timing(input timing_set_t vals, input bit poke_unmapped);
    for (int r = 0; r < REG_COUNT; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
      while (!cfg_ready)
        @(posedge clk);
    end
    if (poke_unmapped) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_UNMAPPED;
      cfg_data  <= DUR_W'($urandom);
      @(posedge clk);
      while (!cfg_ready)
        @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // A short mix of clean, broken and stray traffic under the current windows.
  task automatic exercise_setting();
    send_frame(WORD_W'($urandom), DATA_BITS, -1, 1'b1);
    send_frame(WORD_W'($urandom), DATA_BITS, $urandom_range(STOP_POS, 0), 1'b1);
    send_pulse(1'b1, DUR_W'($urandom));
    send_pulse(1'b0, DUR_W'($urandom));
    settle();
  endtask

  // Window edges under the power-up settings, one duration at a time.
  task automatic test_window_edges();
    // Nothing is open yet, so both extremes are dropped.
    send_pulse(1'b0, DUR_W'(0));
    send_pulse(1'b0, DUR_W'(MAX_DUR));
    // Leader marks outside the window, including both field extremes.
    send_pulse(1'b1, DUR_W'(0));
    send_pulse(1'b1, DUR_W'(MAX_DUR));
    send_pulse(1'b1, RST_LEADER_MARK_MIN - 1);
    send_pulse(1'b1, RST_LEADER_MARK_MAX + 1);
    // The failed frame is closed, so this space is dropped.
    send_pulse(1'b0, RST_LEADER_SPACE_MIN);
    // Leader space just outside either edge.
    send_pulse(1'b1, RST_LEADER_MARK_MIN);
    send_pulse(1'b0, RST_LEADER_SPACE_MIN - 1);
    send_pulse(1'b1, RST_LEADER_MARK_MAX);
    send_pulse(1'b0, RST_LEADER_SPACE_MAX + 1);
    // First data mark too short.
    send_pulse(1'b1, RST_LEADER_MARK_MAX);
    send_pulse(1'b0, RST_LEADER_SPACE_MAX);
    send_pulse(1'b0, RST_BIT_MARK_MIN - 1);
    // A zero at the threshold and a one just above it, then a long mark:
    // the report carries the two bits already collected.
    send_pulse(1'b1, RST_LEADER_MARK_MIN);
    send_pulse(1'b0, RST_LEADER_SPACE_MIN);
    send_pulse(1'b0, RST_BIT_MARK_MIN);
    send_pulse(1'b0, RST_ONE_SPACE_THRESH);
    send_pulse(1'b0, RST_BIT_MARK_MAX);
    send_pulse(1'b0, RST_ONE_SPACE_THRESH + 1);
    send_pulse(1'b0, RST_BIT_MARK_MAX + 1);
    // A start in the middle of a frame drops it silently and restarts.
    send_pulse(1'b1, RST_LEADER_MARK_MIN);
    send_pulse(1'b0, RST_LEADER_SPACE_MAX);
    send_pulse(1'b1, DUR_W'(MAX_DUR));
    settle();
  endtask

  // Complete frames under the power-up settings.
  task automatic test_whole_frames();
    send_frame('1, DATA_BITS, -1, 1'b1);
    send_frame('0, DATA_BITS, -1, 1'b1);
    // Bad stop mark after a full word.
    send_frame(WORD_W'($urandom), DATA_BITS, STOP_POS, 1'b1);
    // Truncated frame overtaken by the next start.
    send_frame(WORD_W'($urandom), 12, -1, 1'b0);
    // Bad data mark somewhere inside the word.
    send_frame(WORD_W'($urandom), DATA_BITS, 2 + 2 * $urandom_range(DATA_BITS - 1, 0), 1'b1);
    // Extra bits: the mark after the last data bit is taken as the stop mark
    // and the rest falls outside the frame.
    send_frame(WORD_W'($urandom), DATA_BITS + 4, -1, 1'b1);
    settle();
  endtask

  // Register extremes: all zero, all full scale, every window empty, every
  // window wide open; then back to the power-up values.
  task automatic test_register_settings();
    timing_set_t vals;
    vals = '{default: '0};
    program_timing(vals, 1'b0);
    exercise_setting();
    vals = '{default: DUR_W'(MAX_DUR)};
    program_timing(vals, 1'b1);
    exercise_setting();
    vals = '{default: DUR_W'(MAX_DUR)};
    vals[REG_LEADER_MARK_MAX]  = '0;
    vals[REG_LEADER_SPACE_MAX] = '0;
    vals[REG_BIT_MARK_MAX]     = '0;
    vals[REG_ONE_SPACE_THRESH] = '0;
    program_timing(vals, 1'b0);
    exercise_setting();
    vals = '{default: DUR_W'(MAX_DUR)};
    vals[REG_LEADER_MARK_MIN]  = '0;
    vals[REG_LEADER_SPACE_MIN] = '0;
    vals[REG_BIT_MARK_MIN]     = '0;
    vals[REG_ONE_SPACE_THRESH] = DUR_W'($urandom);
    program_timing(vals, 1'b0);
    exercise_setting();
    program_timing(DEFAULT_TIMING, 1'b1);
  endtask

  // The receiver holds off for a long stretch while a run of items that each end
  // in a report fills the result register, so the input must stall; a frame follows.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (20)
      send_pulse(1'b1, pick_mark(1'b1, timing[REG_LEADER_MARK_MIN], timing[REG_LEADER_MARK_MAX]));
    send_frame(WORD_W'($urandom), DATA_BITS, -1, 1'b1);
    settle();
  endtask

  // Mostly well-formed frames with random words, mixed with broken, cut-short
  // and over-long frames and bursts of stray durations. Windows are
  // reprogrammed every few frames, and some frames run with no idling.
  task automatic test_random_traffic();
    int item_goal;
    int frames;
    int pick;
    timing_set_t vals;
    item_goal = engaged_items + RANDOM_ITEMS;
    frames    = 0;
    while (engaged_items < item_goal) begin
      if (frames % 3 == 2) begin
        settle();
        if ($urandom_range(3, 0) == 0) begin
          vals = DEFAULT_TIMING;
        end else begin
          vals[REG_LEADER_MARK_MIN]  = DUR_W'($urandom_range(12000, 2000));
          vals[REG_LEADER_MARK_MAX]  = DUR_W'(vals[REG_LEADER_MARK_MIN] +
                                              $urandom_range(4000, 0));
          vals[REG_LEADER_SPACE_MIN] = DUR_W'($urandom_range(6000, 1000));
          vals[REG_LEADER_SPACE_MAX] = DUR_W'(vals[REG_LEADER_SPACE_MIN] +
                                              $urandom_range(3000, 0));
          vals[REG_BIT_MARK_MIN]     = DUR_W'($urandom_range(900, 0));
          vals[REG_BIT_MARK_MAX]     = DUR_W'(vals[REG_BIT_MARK_MIN] +
                                              $urandom_range(1200, 0));
          vals[REG_ONE_SPACE_THRESH] = DUR_W'($urandom_range(3000, 100));
        end
        program_timing(vals, 1'($urandom_range(1, 0)));
      end
      quiet = (frames % 4) == 1;
      pick  = $urandom_range(99, 0);
      if (pick < 65)
        send_frame(WORD_W'($urandom), DATA_BITS, -1, 1'b1);
      else if (pick < 78)
        send_frame(WORD_W'($urandom), DATA_BITS, $urandom_range(STOP_POS, 0), 1'b1);
      else if (pick < 86)
        send_frame(WORD_W'($urandom), $urandom_range(DATA_BITS - 1, 0), -1, 1'b0);
      else if (pick < 90)
        send_frame(WORD_W'($urandom), $urandom_range(DATA_BITS + 8, DATA_BITS + 1), -1, 1'b1);
      else
        repeat ($urandom_range(6, 1))
          send_pulse($urandom_range(4, 0) == 0, DUR_W'($urandom));
      frames++;
    end
    quiet = 1'b0;
  endtask

  // Receiver side: random stalls, a counted hold-off on request, and none
  // at all while quiet is set.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PCT);
      end
    end
  end

  // Follows every transfer on the three channels. Register writes and input
  // items update the local state; each output transfer is checked against
  // the oldest report still due.
  always @(posedge clk) begin : report_checker
    out_item_t want;
    if (rst) begin
      timing       = DEFAULT_TIMING;
      frame_open   = 1'b0;
      frame_pos    = 0;
      shifted_bits = '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < REG_COUNT)
        timing[cfg_index] = cfg_data;
      if (in_valid && !in_stall) begin
        if (in_data.start_of_frame || frame_open)
          engaged_items++;
        if (decode_pulse(in_data, want))
          frame_reports_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (frame_reports_due.size() == 0) begin
          $error("unexpected report transfer: status %0d data_word %h",
                 out_data.status, out_data.data_word);
          errors++;
        end else begin
          want = frame_reports_due.pop_front();
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.data_word !== want.data_word) begin
            $error("data_word mismatch: expected %h, actual %h",
                   want.data_word, out_data.data_word);
            errors++;
          end
        end
      end
    end
  end

  // Global watchdog, generous against the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_window_edges();
    test_whole_frames();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    settle();

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/irpfd_pkg.sv
rtl/irpfd_step.sv
rtl/ir_pulse_frame_decoder.sv
sim/tb_ir_pulse_frame_decoder.sv
